[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants of the text console writer
// Screen geometry, field widths, byte codes, SGR codes and the command type
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry and escape parameter count
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 30;
	localparam int MAX_PARAMS = 8;

	// Field widths, fixed by the port definition
	localparam int BYTE_W  = 8;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int COLOR_W = 4;
	localparam int SLOT_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'd1;

	// Color values after reset
	localparam logic [COLOR_W-1:0] FG_RESET = 4'd8;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

	// Result kinds
	localparam logic KIND_CELL   = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// Command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Byte codes
	localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SGR_END = 8'h6D;

	// SGR codes
	localparam logic [BYTE_W-1:0] SGR_RESET      = 8'd0;
	localparam logic [BYTE_W-1:0] SGR_FG_DEFAULT = 8'd39;
	localparam logic [BYTE_W-1:0] SGR_BG_DEFAULT = 8'd49;
	localparam logic [BYTE_W-1:0] SGR_FG_FIRST   = 8'd30;
	localparam logic [BYTE_W-1:0] SGR_FG_LAST    = 8'd37;
	localparam logic [BYTE_W-1:0] SGR_BG_FIRST   = 8'd40;
	localparam logic [BYTE_W-1:0] SGR_BG_LAST    = 8'd47;

	// Byte classes found by the front end
	typedef enum logic [2:0] {
		CLS_BS,
		CLS_NL,
		CLS_ESC,
		CLS_DIGIT,
		CLS_BRACKET,
		CLS_SEP,
		CLS_SGR,
		CLS_OTHER
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t         cls;
		logic [BYTE_W-1:0] text;
	} cmd_t;

endpackage

[rtl/core/tcw_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ifs - channel interfaces of the text console writer
// Text byte input channel and cell / scroll result channel, valid-ready.
// ----------------------------------------------------------------------------
interface tcw_text_if import tcw_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

interface tcw_cell_if import tcw_pkg::*; ;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   column;
	logic [BYTE_W-1:0]  glyph;
	logic [COLOR_W-1:0] fg_index;
	logic [COLOR_W-1:0] bg_index;
	logic               last;

	modport source (output valid, output kind, output row, output column, output glyph,
		output fg_index, output bg_index, output last, input ready);
	modport sink   (input valid, input kind, input row, input column, input glyph,
		input fg_index, input bg_index, input last, output ready);
endinterface

[rtl/core/ansi_text_console_writer.sv]
`timescale 1ns / 1ps
// A byte passes the front-end register, the command queue and the back-end sequencer; its cell
// result is loaded into the result register from the cell state, after the scroll state when a
// scroll goes first. The back-end sequencer takes the next command only when idle, while the front
// end keeps queueing bytes until the queue is full; the parameter memory is read one entry a cycle while applying.
// Reset (arst_n low, asynchronous) clears cursor and parser, sets colors to 8 / 0 and
// the default registers to 8 / 0; no clearing pass follows.
// ----------------------------------------------------------------------------
// ansi_text_console_writer - text console writer with SGR colors
// Front end classifies text bytes, a short queue decouples it from the back
// end that moves the cursor, parses escapes and emits cell and scroll results.
// ----------------------------------------------------------------------------
module ansi_text_console_writer import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tcw_text_if.sink              text_in,
	tcw_cell_if.source            cell_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COLOR_W-1:0] default_fg_q;
	logic [COLOR_W-1:0] default_bg_q;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               head_vld;
	cmd_t               q_data;
	cmd_t               head;

	// default color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= FG_RESET;
			default_bg_q <= BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEFAULT_FG: default_fg_q <= cfg_data[COLOR_W-1:0];
				CFG_DEFAULT_BG: default_bg_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	tcw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	tcw_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head_vld  (head_vld),
		.head      (head)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (q_pop),
		.default_fg (default_fg_q),
		.default_bg (default_bg_q),
		.cell_out   (cell_out)
	);

endmodule

[rtl/core/tcw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front - byte intake and classification
// Takes text bytes, drops nulls, tags each byte with its class and hands
// the command to the queue through one register stage.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	tcw_text_if.sink       text_in,
	input  logic           q_full,
	output logic           q_push,
	output cmd_t           q_data
);

	logic vld_s1;
	cmd_t cmd_s1;
	logic take;

	function automatic byte_cls_t classify(input logic [BYTE_W-1:0] b);
		byte_cls_t c;
		priority if (b == CH_BS)                     c = CLS_BS;
		else if (b == CH_NL)                         c = CLS_NL;
		else if (b == CH_ESC)                        c = CLS_ESC;
		else if (b >= CH_ZERO && b <= CH_NINE)       c = CLS_DIGIT;
		else if (b == CH_LBRACK)                     c = CLS_BRACKET;
		else if (b == CH_SEMI)                       c = CLS_SEP;
		else if (b == CH_SGR_END)                    c = CLS_SGR;
		else                                         c = CLS_OTHER;
		return c;
	endfunction

	// stage may refill when empty or when it drains this cycle
	assign q_push        = vld_s1 && !q_full;
	assign q_data        = cmd_s1;
	assign text_in.ready = !vld_s1 || !q_full;
	assign take          = text_in.valid && text_in.ready && (text_in.text_byte != CH_NUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.cls  <= classify(text_in.text_byte);
			cmd_s1.text <= text_in.text_byte;
		end
	end

endmodule

[rtl/core/tcw_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cmd_fifo - command queue between front and back end
// Small first-word-fall-through queue of classified commands.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_vld,
	output cmd_t head
);

	cmd_t                 entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 do_pop;

	assign full     = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign head_vld = count_q != '0;
	assign head     = entry_q[rd_ptr_q];
	assign do_pop   = pop && head_vld;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/tcw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back - command execution
// Holds cursor, colors and the escape parser with its parameter memory,
// runs SGR sequences one parameter a cycle and drives the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_vld,
	input  cmd_t               head,
	output logic               pop,
	input  logic [COLOR_W-1:0] default_fg,
	input  logic [COLOR_W-1:0] default_bg,
	tcw_cell_if.source         cell_out
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_SGR,
		ST_SCROLL,
		ST_CELL
	} state_t;

	state_t             state_q;
	logic [COL_W-1:0]   cursor_col_q;
	logic [ROW_W-1:0]   cursor_row_q;
	logic [COLOR_W-1:0] current_fg_q;
	logic [COLOR_W-1:0] current_bg_q;
	logic               esc_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  iter_q;
	logic [MAX_PARAMS-1:0] pvalid_q;
	logic               apply_q;
	logic               cell_pend_q;
	logic               scroll_last_q;
	logic [BYTE_W-1:0]  glyph_q;

	// result register
	logic               out_vld_q;
	logic               kind_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [BYTE_W-1:0]  out_glyph_q;
	logic [COLOR_W-1:0] out_fg_q;
	logic [COLOR_W-1:0] out_bg_q;
	logic               last_q;

	// parameter memory, one read and one write port
	logic [BYTE_W-1:0]  pmem [MAX_PARAMS];
	logic [BYTE_W-1:0]  rd_data_q;
	logic               rd_live_q;
	logic [SLOT_W-1:0]  rd_addr;
	logic               mem_we;

	logic [BYTE_W-1:0]  p;
	logic [BYTE_W-1:0]  p_fg;
	logic [BYTE_W-1:0]  p_bg;
	logic [11:0]        acc;
	logic [BYTE_W-1:0]  dig_val;
	logic [COLOR_W-1:0] fg_n;
	logic [COLOR_W-1:0] bg_n;
	logic               load_ok;
	logic               col_full;
	logic               row_bottom;
	logic [SLOT_W-1:0]  slot_next;

	assign cell_out.valid    = out_vld_q;
	assign cell_out.kind     = kind_q;
	assign cell_out.row      = row_q;
	assign cell_out.column   = col_q;
	assign cell_out.glyph    = out_glyph_q;
	assign cell_out.fg_index = out_fg_q;
	assign cell_out.bg_index = out_bg_q;
	assign cell_out.last     = last_q;

	assign load_ok    = !out_vld_q || cell_out.ready;
	assign pop        = (state_q == ST_IDLE) && head_vld && !apply_q;
	assign col_full   = cursor_col_q >= COL_W'(COLUMNS);
	assign row_bottom = cursor_row_q == ROW_W'(ROWS - 1);
	assign slot_next  = (slot_q == SLOT_W'(MAX_PARAMS - 1)) ? '0 : slot_q + 1'b1;
	assign rd_addr    = (state_q == ST_SGR) ? iter_q : slot_q;
	assign mem_we     = state_q == ST_DIGIT;

	// parameter read back; never-written slots read as zero
	assign p       = rd_live_q ? rd_data_q : '0;
	assign acc     = 12'(p) * 12'd10 + 12'(glyph_q[3:0]);
	assign dig_val = (acc > 12'd255) ? 8'hFF : acc[7:0];
	assign p_fg    = p - SGR_FG_FIRST;
	assign p_bg    = p - SGR_BG_FIRST;

	// effect of one SGR parameter on the colors
	always_comb begin
		fg_n = current_fg_q;
		bg_n = current_bg_q;
		priority if (p == SGR_RESET) begin
			fg_n = default_fg;
			bg_n = default_bg;
		end else if (p == SGR_FG_DEFAULT) begin
			fg_n = default_fg;
		end else if (p == SGR_BG_DEFAULT) begin
			bg_n = default_bg;
		end else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) begin
			fg_n = p_fg[COLOR_W-1:0];
		end else if (p >= SGR_BG_FIRST && p <= SGR_BG_LAST) begin
			bg_n = p_bg[COLOR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pmem[slot_q] <= dig_val;
		end
		rd_data_q <= pmem[rd_addr];
		rd_live_q <= pvalid_q[rd_addr];
	end

	// sequencer, cursor, colors, parser and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			current_fg_q  <= FG_RESET;
			current_bg_q  <= BG_RESET;
			esc_q         <= 1'b0;
			slot_q        <= '0;
			iter_q        <= '0;
			pvalid_q      <= '0;
			apply_q       <= 1'b0;
			cell_pend_q   <= 1'b0;
			scroll_last_q <= 1'b0;
			glyph_q       <= '0;
			out_vld_q     <= 1'b0;
			kind_q        <= KIND_CELL;
			row_q         <= '0;
			col_q         <= '0;
			out_glyph_q   <= '0;
			out_fg_q      <= '0;
			out_bg_q      <= '0;
			last_q        <= 1'b0;
		end else begin
			apply_q <= state_q == ST_SGR;
			if (apply_q) begin
				current_fg_q <= fg_n;
				current_bg_q <= bg_n;
			end
			if (cell_out.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.cls)
							CLS_BS: begin
								if (cursor_col_q != '0) begin
									cursor_col_q <= cursor_col_q - 1'b1;
								end
							end
							CLS_NL: begin
								cursor_col_q <= '0;
								if (row_bottom) begin
									cell_pend_q   <= 1'b0;
									scroll_last_q <= 1'b1;
									state_q       <= ST_SCROLL;
								end else begin
									cursor_row_q <= cursor_row_q + 1'b1;
								end
							end
							CLS_ESC: begin
								esc_q    <= 1'b1;
								slot_q   <= '0;
								pvalid_q <= '0;
							end
							default: begin
								glyph_q <= head.text;
								if (esc_q) begin
									// escape sequence body
									unique case (head.cls)
										CLS_DIGIT:   state_q <= ST_DIGIT;
										CLS_BRACKET: ;
										CLS_SEP:     slot_q <= slot_next;
										CLS_SGR: begin
											esc_q   <= 1'b0;
											iter_q  <= '0;
											state_q <= ST_SGR;
										end
										default:     esc_q <= 1'b0;
									endcase
								end else if (col_full) begin
									// printable byte past the right edge wraps first
									cursor_col_q <= '0;
									if (row_bottom) begin
										cell_pend_q   <= 1'b1;
										scroll_last_q <= 1'b0;
										state_q       <= ST_SCROLL;
									end else begin
										cursor_row_q <= cursor_row_q + 1'b1;
										state_q      <= ST_CELL;
									end
								end else begin
									state_q <= ST_CELL;
								end
							end
						endcase
					end
				end
				ST_DIGIT: begin
					pvalid_q[slot_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_SGR: begin
					if (iter_q == slot_q) begin
						state_q <= ST_IDLE;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_SCROLL: begin
					if (load_ok) begin
						out_vld_q   <= 1'b1;
						kind_q      <= KIND_SCROLL;
						row_q       <= '0;
						col_q       <= '0;
						out_glyph_q <= '0;
						out_fg_q    <= '0;
						out_bg_q    <= '0;
						last_q      <= scroll_last_q;
						state_q     <= cell_pend_q ? ST_CELL : ST_IDLE;
					end
				end
				ST_CELL: begin
					if (load_ok) begin
						out_vld_q    <= 1'b1;
						kind_q       <= KIND_CELL;
						row_q        <= cursor_row_q;
						col_q        <= cursor_col_q;
						out_glyph_q  <= glyph_q;
						out_fg_q     <= current_fg_q;
						out_bg_q     <= current_bg_q;
						last_q       <= 1'b1;
						cursor_col_q <= cursor_col_q + 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/tcw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker - port-level checks of the text console writer
// Watches the result channel: stall behavior and the shape of results.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               kind,
	input logic [ROW_W-1:0]   row,
	input logic [COL_W-1:0]   column,
	input logic [BYTE_W-1:0]  glyph,
	input logic [COLOR_W-1:0] fg_index,
	input logic [COLOR_W-1:0] bg_index,
	input logic               last
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// scroll results carry an all-zero payload
	a_scroll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SCROLL |->
			row == '0 && column == '0 && glyph == '0 && fg_index == '0 && bg_index == '0)
		else $error("scroll result with nonzero payload");

	// a cell write always closes its byte's results
	a_cell_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CELL |-> last)
		else $error("cell write without last");

	// cell writes stay on screen
	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CELL |-> row < ROW_W'(ROWS) && 9'(column) < 9'(COLUMNS))
		else $error("cell write off screen");

endmodule

bind ansi_text_console_writer tcw_checker u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (cell_out.valid),
	.out_ready (cell_out.ready),
	.kind      (cell_out.kind),
	.row       (cell_out.row),
	.column    (cell_out.column),
	.glyph     (cell_out.glyph),
	.fg_index  (cell_out.fg_index),
	.bg_index  (cell_out.bg_index),
	.last      (cell_out.last)
);
